[rtl/core/mme_pkg.sv]
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_MARKER_BYTES = 8;
  localparam int WINDOW_W         = 8 * MAX_MARKER_BYTES;
  localparam int LEN_W            = 4;
  localparam int COUNT_W          = 8;
  localparam int INDEX_W          = 2;

  // Register indexes on the configuration port
  localparam logic [INDEX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [INDEX_W-1:0] REG_LENGTH  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_CAPTURE = 2'd2;

  // Scan phases
  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_CAPTURE = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_FOUND    = 2'd1;
  localparam logic [1:0] KIND_NOTFOUND = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MARKER_BYTES);

endpackage

[rtl/core/marker_match_and_extract.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// byte      in         byte_valid / byte_stall   in_byte[7:0], scan_end
// result    out        result_valid / result_stall  result_kind[1:0], out_byte[7:0], run_end
// cfg       in         cfg_valid / cfg_ready     cfg_index[1:0], cfg_data[63:0]
//
// One byte per cycle while byte_stall is low: a byte is compared against the marker window and its result,
// if any, is registered in the same cycle and shown on the next.
// The single result register sets the rate; byte_stall is high only while that
// register holds a result that result_stall is holding back.
// rst (synchronous) clears the scan state, the configuration registers and result_valid to their reset values.
// cfg_ready is always high; a write takes effect from the next byte.

module marker_match_and_extract (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          in_byte,
  input  logic                                scan_end,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          result_kind,
  output logic [7:0]                          out_byte,
  output logic                                run_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mme_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [mme_pkg::WINDOW_W-1:0]        cfg_data
);

  logic [mme_pkg::WINDOW_W-1:0] marker_pattern;
  logic [mme_pkg::LEN_W-1:0]    marker_length;
  logic [mme_pkg::COUNT_W-1:0]  capture_count;

  logic [mme_pkg::WINDOW_W-1:0] recent_window, recent_window_next;
  logic [mme_pkg::LEN_W-1:0]    window_fill, window_fill_next;
  logic [1:0]                   scan_phase, scan_phase_next;
  logic [mme_pkg::COUNT_W-1:0]  bytes_left, bytes_left_next, bytes_left_dec;

  logic                         emit;
  logic [1:0]                   kind_next;
  logic [7:0]                   byte_next;
  logic                         end_next;

  logic                         accept;
  logic [mme_pkg::LEN_W-1:0]    eff_len;
  logic [mme_pkg::WINDOW_W-1:0] shifted;
  logic [mme_pkg::MAX_MARKER_BYTES-1:0] byte_ok;
  logic                         match;

  assign cfg_ready  = 1'b1;
  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_pattern <= '0;
      marker_length  <= mme_pkg::LEN_W'(1);
      capture_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mme_pkg::REG_PATTERN: marker_pattern <= cfg_data;
        mme_pkg::REG_LENGTH:  marker_length  <= cfg_data[mme_pkg::LEN_W-1:0];
        mme_pkg::REG_CAPTURE: capture_count  <= cfg_data[mme_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the marker length into 1..MAX_MARKER_BYTES
  always_comb begin
    if (marker_length == '0) begin
      eff_len = mme_pkg::LEN_W'(1);
    end else if (marker_length > mme_pkg::LEN_MAX) begin
      eff_len = mme_pkg::LEN_MAX;
    end else begin
      eff_len = marker_length;
    end
  end

  assign shifted = {recent_window[mme_pkg::WINDOW_W-9:0], in_byte};

  always_comb begin
    for (int i = 0; i < mme_pkg::MAX_MARKER_BYTES; i++) begin
      byte_ok[i] = (shifted[8*i +: 8] == marker_pattern[8*i +: 8]) ||
                   (mme_pkg::LEN_W'(i) >= eff_len);
    end
  end

  assign window_fill_next = (window_fill < mme_pkg::LEN_MAX) ?
                            window_fill + mme_pkg::LEN_W'(1) : window_fill;
  assign match = (window_fill_next >= eff_len) && (&byte_ok);
  assign bytes_left_dec = (bytes_left != '0) ? bytes_left - mme_pkg::COUNT_W'(1) : bytes_left;

  always_comb begin
    recent_window_next = recent_window;
    scan_phase_next    = scan_phase;
    bytes_left_next    = bytes_left;
    emit               = 1'b0;
    kind_next          = mme_pkg::KIND_BYTE;
    byte_next          = '0;
    end_next           = 1'b0;
    case (scan_phase)
      mme_pkg::PH_SEARCH: begin
        recent_window_next = shifted;
        if (match) begin
          emit      = 1'b1;
          kind_next = mme_pkg::KIND_FOUND;
          end_next  = scan_end || (capture_count == '0);
          if (capture_count == '0) begin
            scan_phase_next = mme_pkg::PH_DONE;
          end else begin
            scan_phase_next = mme_pkg::PH_CAPTURE;
            bytes_left_next = capture_count;
          end
        end else if (scan_end) begin
          emit      = 1'b1;
          kind_next = mme_pkg::KIND_NOTFOUND;
          end_next  = 1'b1;
        end
      end
      mme_pkg::PH_CAPTURE: begin
        bytes_left_next = bytes_left_dec;
        emit            = 1'b1;
        kind_next       = mme_pkg::KIND_BYTE;
        byte_next       = in_byte;
        end_next        = scan_end || (bytes_left_dec == '0);
        if (bytes_left_dec == '0) begin
          scan_phase_next = mme_pkg::PH_DONE;
        end
      end
      default: begin
        scan_phase_next = mme_pkg::PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_window <= '0;
      window_fill   <= '0;
      scan_phase    <= mme_pkg::PH_SEARCH;
      bytes_left    <= '0;
    end else if (accept) begin
      if (scan_end) begin
        recent_window <= '0;
        window_fill   <= '0;
        scan_phase    <= mme_pkg::PH_SEARCH;
        bytes_left    <= '0;
      end else begin
        recent_window <= recent_window_next;
        // fill only counts while searching
        if (scan_phase == mme_pkg::PH_SEARCH) begin
          window_fill <= window_fill_next;
        end
        scan_phase    <= scan_phase_next;
        bytes_left    <= bytes_left_next;
      end
    end
  end

  // Result register: load on an accepted request that emits, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= emit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result_kind <= kind_next;
      out_byte    <= byte_next;
      run_end     <= end_next;
    end
  end

endmodule
